### design/csfc_pkg.sv
// Package for the similarity cache: request codes, register indexes, widths.
// No dependencies.
`timescale 1ns / 1ps
package csfc_pkg;
    localparam logic [1:0] REQ_CHECK  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [0:0] REG_CACHE_SIZE = 1'd0;
    localparam logic [0:0] REG_THRESHOLD  = 1'd1;
    localparam int SUM_W = 64;
endpackage

### design/cosine_similarity_fifo_cache.sv
// Similarity cache top level: FIFO of feature vectors matched by cosine similarity.
// Uses csfc_pkg and csfc_ram.
`timescale 1ns / 1ps
//  channel  | dir | payload
//  s_axis   | in  | tdata {id, element}, tlast last_element, tuser req_type
//  m_axis   | out | tdata {match_id, hit}
//  cfg      | in  | index, data
// A check element runs one shared multiplier over every slot, each in a read state
// (S_DRD) and a multiply-accumulate state (S_DMAC). Add, clear, ignored items and a
// check element past MAX_DIM are handled in S_IDLE alone. A last check element then
// compares entries oldest first, S_CRD to S_CMP per entry. The result waits in an output
// register; a second result holds the block until the first is taken.
// Reset is synchronous: cache empty, sums zero, cache_size 8, threshold 11469.
module cosine_similarity_fifo_cache #(
    parameter int CAPACITY     = 16,
    parameter int MAX_DIM      = 512,
    parameter int ELEMENT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // element_value[15:0], entry_id[31:16]
    input  logic        s_axis_tlast,
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // hit[0], match_id[16:1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int IW = $clog2(MAX_DIM + 1);
    localparam int EB = (ELEMENT_BITS < 16) ? ELEMENT_BITS : 16;
    localparam int AW = $clog2(CAPACITY * MAX_DIM);
    localparam int SUM_W = csfc_pkg::SUM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DRD, S_DMAC, S_CSTART, S_CRD, S_M0, S_M1, S_M2, S_M3, S_MUL2,
        S_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0]  r_cache_size;
    logic signed [15:0] r_thr;
    logic [SUM_W-1:0] r_dot [CAPACITY];
    logic [SUM_W-1:0] r_norm_q;
    logic [SUM_W-1:0] r_norm_e [CAPACITY];
    logic [15:0] r_ids [CAPACITY];
    logic [IW-1:0] r_idx;
    logic [SW-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic signed [15:0] r_v;
    logic r_last;
    logic [DW-1:0] r_pos;
    logic r_hit;
    logic [15:0] r_mid;
    logic r_o_valid;
    logic r_o_hit;
    logic [15:0] r_o_mid;
    // compare pass operands
    logic [SUM_W-1:0] r_a, r_b;
    logic [2*SUM_W-1:0] r_acc;
    logic [2*SUM_W-1:0] r_lhs;
    logic [2*SUM_W-1:0] r_rhs;
    logic [31:0] r_tt;
    logic [1:0] r_pi, r_pj;
    logic [SW-1:0] r_slot;

    logic signed [15:0] w_v;
    logic [SW-1:0] w_wslot;
    logic [AW-1:0] w_waddr, w_raddr;
    logic w_we;
    logic [15:0] w_rdata;
    logic [31:0] w_pa, w_pb;
    logic [63:0] w_prod;
    logic [SW:0] w_sum_slot;
    logic w_load;

    assign w_v = 16'(signed'(s_axis_tdata[EB-1:0]));
    assign w_sum_slot = (SW+1)'(r_oldest) + ((r_count < CW'(CAPACITY)) ? (SW+1)'(r_count) : '0);
    assign w_wslot = (w_sum_slot >= (SW+1)'(CAPACITY)) ? SW'(w_sum_slot - (SW+1)'(CAPACITY))
                                                        : SW'(w_sum_slot);
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata = {7'd0, r_o_mid, r_o_hit};
    assign w_load = (r_state == S_OUT) && (!r_o_valid || m_axis_tready);

    logic w_acc_in, w_inr;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign w_inr = r_idx < IW'(MAX_DIM);
    assign w_we = w_acc_in && s_axis_tuser == csfc_pkg::REQ_ADD && w_inr;
    assign w_waddr = AW'(w_wslot) * AW'(MAX_DIM) + AW'(r_idx[DW-1:0]);
    assign w_raddr = AW'(r_k[SW-1:0]) * AW'(MAX_DIM) + AW'(r_pos);

    csfc_ram #(.WIDTH(16), .DEPTH(CAPACITY * MAX_DIM)) u_vec (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_v),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // one shared 32x32 multiplier: operand halves chosen by r_pi/r_pj, except in S_DMAC, S_M3 and S_MUL2
    always_comb begin
        w_pa = r_pi[0] ? r_a[63:32] : r_a[31:0];
        w_pb = r_pj[0] ? r_b[63:32] : r_b[31:0];
        case (r_state)
            S_DMAC: begin
                w_pa = 32'(signed'(w_rdata));
                w_pb = 32'(signed'(r_v));
            end
            S_M3: begin
                w_pa = 32'(w_t);
                w_pb = 32'(w_t);
            end
            S_MUL2: begin
                w_pa = r_acc[{r_pi, 5'd0} +: 32];
                w_pb = r_tt;
            end
            default: ;
        endcase
    end
    assign w_prod = (r_state == S_DMAC) ? 64'(signed'(w_pa) * signed'(w_pb)) : w_pa * w_pb;

    logic [SUM_W-1:0] w_vsq;
    assign w_vsq = 64'(signed'(w_v) * signed'(w_v));

    logic w_neg, w_tpos;
    logic [SUM_W-1:0] w_mag, w_dot;
    logic [15:0] w_t;
    assign w_dot = r_dot[r_slot];
    assign w_neg = w_dot[63];
    assign w_mag = w_neg ? -w_dot : w_dot;
    assign w_tpos = r_thr > 0;
    assign w_t = r_thr[15] ? 16'(-r_thr) : r_thr;

    logic w_reach;
    always_comb begin
        if (r_norm_e[r_slot] == '0 || r_norm_q == '0) w_reach = !w_tpos;
        else if (w_tpos && (w_neg || w_mag == '0)) w_reach = 1'b0;
        else if (!w_tpos && !w_neg) w_reach = 1'b1;
        else if (w_tpos) w_reach = r_lhs >= r_rhs;
        else w_reach = r_lhs <= r_rhs;
    end

    logic [CW-1:0] w_limit;
    assign w_limit = (32'(r_cache_size) < 32'(CAPACITY)) ? CW'(r_cache_size) : CW'(CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cache_size <= 5'd8;
            r_thr <= 16'sd11469;
            r_idx <= '0;
            r_oldest <= '0;
            r_count <= '0;
            r_norm_q <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) r_dot[i] <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == csfc_pkg::REG_CACHE_SIZE) r_cache_size <= i_cfg_data[4:0];
                else r_thr <= i_cfg_data;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
                r_o_hit <= r_hit;
                r_o_mid <= r_mid;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (w_acc_in) begin
                    r_v <= w_v;
                    r_last <= s_axis_tlast;
                    r_pos <= r_idx[DW-1:0];
                    case (s_axis_tuser)
                        csfc_pkg::REQ_CLEAR: begin
                            r_count <= '0; r_oldest <= '0; r_norm_q <= '0; r_idx <= '0;
                            for (int i = 0; i < CAPACITY; i++) r_dot[i] <= '0;
                        end
                        csfc_pkg::REQ_ADD: begin
                            r_idx <= s_axis_tlast ? '0 : (w_inr ? r_idx + 1'b1 : r_idx);
                            r_ids[w_wslot] <= s_axis_tdata[31:16];
                            if (w_inr)
                                r_norm_e[w_wslot] <= ((r_idx == '0) ? '0 : r_norm_e[w_wslot])
                                                     + w_vsq;
                            if (s_axis_tlast) begin
                                logic [CW:0] c;
                                logic [SW:0] o;
                                c = (r_count < CW'(CAPACITY)) ? (CW+1)'(r_count) + 1'b1
                                                             : (CW+1)'(r_count);
                                o = (SW+1)'(r_oldest) + ((r_count < CW'(CAPACITY)) ? '0 : 1'b1);
                                if (c > (CW+1)'(w_limit)) o = o + (SW+1)'(c - (CW+1)'(w_limit));
                                if (c > (CW+1)'(w_limit)) c = (CW+1)'(w_limit);
                                if (o >= (SW+1)'(CAPACITY)) o = o - (SW+1)'(CAPACITY);
                                if (o >= (SW+1)'(CAPACITY)) o = o - (SW+1)'(CAPACITY);
                                r_count <= CW'(c);
                                r_oldest <= SW'(o);
                            end
                        end
                        csfc_pkg::REQ_CHECK: begin
                            r_idx <= s_axis_tlast ? '0 : (w_inr ? r_idx + 1'b1 : r_idx);
                            r_k <= '0;
                            if (w_inr) begin
                                r_norm_q <= r_norm_q + w_vsq;
                                r_state <= S_DRD;
                            end else if (s_axis_tlast) begin
                                r_state <= S_CSTART;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DRD: r_state <= S_DMAC;
                S_DMAC: begin
                    r_dot[r_k[SW-1:0]] <= r_dot[r_k[SW-1:0]] + w_prod;
                    if (r_k == CW'(CAPACITY - 1)) begin
                        r_state <= r_last ? S_CSTART : S_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_CSTART: begin
                    r_hit <= 1'b0; r_mid <= '0; r_k <= '0;
                    r_state <= (r_count == '0) ? S_OUT : S_CRD;
                    r_slot <= r_oldest;
                end
                S_CRD: begin
                    // square the dot magnitude
                    r_a <= w_mag; r_b <= w_mag; r_acc <= '0;
                    r_pi <= 2'd0; r_pj <= 2'd0;
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_acc <= r_acc + ({64'd0, w_prod} << (32 * (int'(r_pi) + int'(r_pj))));
                    if (r_pi[0] && r_pj[0]) begin
                        r_state <= S_M1;
                    end else if (r_pj[0]) begin
                        r_pj <= 2'd0; r_pi <= 2'd1;
                    end else r_pj <= 2'd1;
                end
                S_M1: begin
                    r_lhs <= r_acc << 28;
                    r_a <= r_norm_e[r_slot]; r_b <= r_norm_q; r_acc <= '0;
                    r_pi <= 2'd0; r_pj <= 2'd0;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc <= r_acc + ({64'd0, w_prod} << (32 * (int'(r_pi) + int'(r_pj))));
                    if (r_pi[0] && r_pj[0]) begin
                        r_state <= S_M3;
                    end else if (r_pj[0]) begin
                        r_pj <= 2'd0; r_pi <= 2'd1;
                    end else r_pj <= 2'd1;
                end
                S_M3: begin
                    r_tt <= w_prod[31:0];
                    r_rhs <= '0;
                    r_pi <= 2'd0;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_rhs <= r_rhs + ({64'd0, w_prod} << {r_pi, 5'd0});
                    if (r_pi == 2'd3) r_state <= S_CMP;
                    else r_pi <= r_pi + 1'b1;
                end
                S_CMP: begin
                    if (w_reach) begin
                        r_hit <= 1'b1; r_mid <= r_ids[r_slot];
                        r_state <= S_OUT;
                    end else if (r_k + 1'b1 >= r_count) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_slot <= (r_slot == SW'(CAPACITY - 1)) ? '0 : r_slot + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_OUT: if (w_load) begin
                    r_norm_q <= '0;
                    for (int i = 0; i < CAPACITY; i++) r_dot[i] <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### design/csfc_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module csfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### bench/cosine_similarity_fifo_cache_test.sv
// Self-checking bench for cosine_similarity_fifo_cache: streams check, add, clear and unused items,
// predicts each match result and compares it. Depends on csfc_pkg and the block's RTL.
`timescale 1ns / 1ps
module cosine_similarity_fifo_cache_test;
    localparam int CAP = 16;
    localparam int DIM_MAX = 512;
    localparam int VEC_LEN = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic        hit;
        logic [15:0] id;
    } match_t;

    class csfc_scoreboard;
        logic signed [15:0] vecs[CAP][DIM_MAX];
        logic [15:0] ids[CAP];
        logic [63:0] norms[CAP];
        logic [63:0] dots[CAP];
        logic [63:0] query_norm;
        int unsigned pos, oldest, count;
        logic [4:0] size_reg;
        logic signed [15:0] thr_reg;
        match_t pending[EXP_DEPTH];
        int unsigned head, tail, fill;
        int errors;

        function new();
            errors = 0;
            head = 0;
            tail = 0;
            fill = 0;
            clear_all();
            size_reg = 5'd8;
            thr_reg = 16'sd11469;
        endfunction

        function void clear_all();
            foreach (dots[k]) dots[k] = '0;
            query_norm = '0;
            pos = 0;
            oldest = 0;
            count = 0;
        endfunction

        function void add_expected(match_t m);
            pending[tail] = m;
            tail = (tail + 1) % EXP_DEPTH;
            fill++;
        endfunction

        function match_t take_expected();
            match_t m;
            m = pending[head];
            head = (head + 1) % EXP_DEPTH;
            fill--;
            return m;
        endfunction

        function int unsigned outstanding();
            return fill;
        endfunction

        function void note_config(logic idx, logic [15:0] data);
            if (idx == csfc_pkg::REG_CACHE_SIZE) size_reg = data[4:0];
            else thr_reg = data;
        endfunction

        function bit reaches(logic [63:0] dot, logic [63:0] n1, logic [63:0] n2,
                             logic signed [15:0] th);
            logic neg;
            logic [63:0] mag;
            logic [31:0] t;
            logic [127:0] lhs, rhs;
            neg = dot[63];
            mag = neg ? -dot : dot;
            t = (th < 0) ? 32'(-int'(th)) : 32'(int'(th));
            if (n1 == 0 || n2 == 0) return th <= 0;
            if (th > 0 && (neg || mag == 0)) return 0;
            if (th <= 0 && !neg) return 1;
            lhs = (128'(mag) * 128'(mag)) << 28;
            rhs = 128'(n1) * 128'(n2) * 128'(t) * 128'(t);
            return (th > 0) ? (lhs >= rhs) : (lhs <= rhs);
        endfunction

        function void note_item(logic [1:0] req, logic signed [15:0] v, logic [15:0] id,
                                logic last);
            int unsigned p, slot, lim;
            bit inr;
            match_t m;
            p = pos;
            inr = p < DIM_MAX;
            if (req == csfc_pkg::REQ_CLEAR) begin
                clear_all();
                return;
            end
            if (req != csfc_pkg::REQ_CHECK && req != csfc_pkg::REQ_ADD) return;
            pos = last ? 0 : (inr ? p + 1 : p);
            if (req == csfc_pkg::REQ_ADD) begin
                lim = (size_reg < CAP) ? size_reg : CAP;
                slot = (oldest + ((count < CAP) ? count : 0)) % CAP;
                ids[slot] = id;
                if (inr) begin
                    vecs[slot][p] = v;
                    if (p == 0) norms[slot] = '0;
                    norms[slot] += 64'(longint'(v) * longint'(v));
                end
                if (last) begin
                    if (count < CAP) count++;
                    else oldest = (oldest + 1) % CAP;
                    while (count > lim) begin
                        oldest = (oldest + 1) % CAP;
                        count--;
                    end
                end
                return;
            end
            if (inr) begin
                for (int k = 0; k < CAP; k++)
                    dots[k] += 64'(longint'(vecs[k][p]) * longint'(v));
                query_norm += 64'(longint'(v) * longint'(v));
            end
            if (!last) return;
            m = '0;
            for (int k = 0; k < count; k++) begin
                slot = (oldest + k) % CAP;
                if (reaches(dots[slot], norms[slot], query_norm, thr_reg)) begin
                    m.hit = 1'b1;
                    m.id = ids[slot];
                    break;
                end
            end
            add_expected(m);
            foreach (dots[k]) dots[k] = '0;
            query_norm = '0;
        endfunction

        function void check_result(logic hit, logic [15:0] id);
            match_t m;
            if (fill == 0) begin
                $error("unexpected result: hit %0d match_id %0d", hit, id);
                errors++;
                return;
            end
            m = take_expected();
            if (hit !== m.hit) begin
                $error("hit: expected %0d, actual %0d", m.hit, hit);
                errors++;
            end
            if (id !== m.id) begin
                $error("match_id: expected %0d, actual %0d", m.id, id);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // element_value[15:0], entry_id[31:16]
    logic        s_axis_tlast = 1'b0;
    logic [1:0]  s_axis_tuser = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // hit[0], match_id[16:1]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    logic        long_hold = 1'b0;
    logic        stall_go = 1'b0;
    logic        gaps_on = 1'b1;
    int          rx_wait = 0;
    int unsigned cycles = 0;
    csfc_scoreboard sb = new();

    cosine_similarity_fifo_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("cosine_similarity_fifo_cache_test: FAIL");
            $finish;
        end
    end

    // take results, idling for a random count after each one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata[0], m_axis_tdata[16:1]);
                rx_wait = gaps_on ? $urandom_range(0, 10) : 0;
            end
            if (long_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // hold off the result side for a long stretch
    initial begin
        @(posedge stall_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (2000) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic send_item(logic [1:0] req, logic signed [15:0] v, logic [15:0] id,
                             logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {id, v};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(req, v, id, last);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.note_config(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(logic [1:0] req, int len);
        logic [15:0] id;
        logic signed [15:0] v;
        int slot, mode;
        bit last;
        id = 16'($urandom);
        slot = $urandom_range(0, CAP - 1);
        mode = $urandom_range(0, 3);
        for (int e = 0; e < len; e++) begin
            last = (e == len - 1) || (sb.pos >= VEC_LEN - 1);
            if (req == csfc_pkg::REQ_CHECK && mode == 0)
                v = sb.vecs[slot][sb.pos];
            else if (req == csfc_pkg::REQ_CHECK && mode == 1)
                v = sb.vecs[slot][sb.pos] + 16'($signed($urandom_range(0, 2000)) - 1000);
            else if (req == csfc_pkg::REQ_CHECK && mode == 2)
                v = -sb.vecs[slot][sb.pos];
            else
                v = pick_value();
            send_item(req, v, id, last);
            if (last) break;
        end
    endtask

    task automatic random_items(int n);
        int r;
        logic [1:0] req;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_vector(csfc_pkg::REQ_CHECK, (r < 45) ? VEC_LEN : $urandom_range(1, VEC_LEN));
            end else if (r < 85) begin
                send_vector(csfc_pkg::REQ_ADD, (r < 80) ? VEC_LEN : $urandom_range(1, VEC_LEN));
            end else if (r < 89) begin
                send_item(csfc_pkg::REQ_CLEAR, pick_value(), 16'($urandom), 1'($urandom));
            end else if (r < 93) begin
                send_item(csfc_pkg::REQ_UNUSED, pick_value(), 16'($urandom), 1'($urandom));
            end else begin
                // break a vector: mixed requests sharing one position
                req = $urandom_range(0, 1) ? csfc_pkg::REQ_ADD : csfc_pkg::REQ_CHECK;
                send_item(req, pick_value(), 16'($urandom),
                          (sb.pos >= VEC_LEN - 1) ? 1'b1 : 1'($urandom_range(0, 3) == 0));
            end
        end
    endtask

    initial begin
        logic [4:0] sizes[6];
        logic [15:0] thrs[6];
        sizes = '{5'd16, 5'd0, 5'd31, 5'd4, 5'd1, 5'd12};
        thrs = '{16'd0, 16'd11469, 16'hC000, 16'h4000, 16'h8000, 16'h7FFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot at every position used by later checks
        write_reg(csfc_pkg::REG_CACHE_SIZE, 16'd16);
        for (int s = 0; s < CAP; s++)
            for (int e = 0; e < VEC_LEN; e++)
                send_item(csfc_pkg::REQ_ADD, pick_value(), 16'($urandom), e == VEC_LEN - 1);

        for (int e = 0; e < VEC_LEN; e++)
            send_item(csfc_pkg::REQ_CHECK, 16'sd0, 16'd0, e == VEC_LEN - 1);
        for (int e = 0; e < VEC_LEN; e++)
            send_item(csfc_pkg::REQ_CHECK, -16'sd32768, 16'hFFFF, e == VEC_LEN - 1);
        send_item(csfc_pkg::REQ_CHECK, 16'sd32767, 16'd0, 1'b1);
        send_item(csfc_pkg::REQ_UNUSED, 16'sd32767, 16'hFFFF, 1'b1);
        send_item(csfc_pkg::REQ_CHECK, 16'sd5, 16'd0, 1'b0);
        send_item(csfc_pkg::REQ_CLEAR, 16'sd5, 16'd0, 1'b1);
        send_item(csfc_pkg::REQ_CHECK, 16'sd100, 16'd0, 1'b1);
        send_item(csfc_pkg::REQ_ADD, 16'sd100, 16'hA5A5, 1'b1);
        send_item(csfc_pkg::REQ_CHECK, 16'sd100, 16'd0, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 6) begin
                write_reg(csfc_pkg::REG_CACHE_SIZE, {11'b0, sizes[ph]});
                write_reg(csfc_pkg::REG_THRESHOLD, thrs[ph]);
            end else begin
                write_reg(csfc_pkg::REG_CACHE_SIZE, 16'($urandom_range(0, 31)));
                write_reg(csfc_pkg::REG_THRESHOLD, 16'($urandom_range(0, 65535)));
            end
            gaps_on <= (ph != 4);
            if (ph == 2) stall_go <= 1'b1;
            random_items(16);
            drain();
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("cosine_similarity_fifo_cache_test: PASS");
        else
            $display("cosine_similarity_fifo_cache_test: FAIL");
        $finish;
    end
endmodule

### cosine_similarity_fifo_cache.f
design/csfc_pkg.sv
design/csfc_ram.sv
design/cosine_similarity_fifo_cache.sv
bench/cosine_similarity_fifo_cache_test.sv
